### rtl/core/lkvc_pkg.sv
// ============================================================================
// LRU key-value cache package
// Item types, field widths, register map and defaults shared by the cache.
// ============================================================================
package lkvc_pkg;

    localparam int KEY_W           = 32;
    localparam int DATA_W          = 32;
    localparam int CAP_W           = 5;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;
    localparam int ENTRIES_DEFAULT = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
    } rsp_t;

endpackage

### rtl/core/lru_key_value_cache_top.sv
// ============================================================================
// LRU key-value cache
// Fully associative key-value cache with least-recently-used replacement,
// APB capacity register and valid/stall item channels.
// ============================================================================
// The cache takes one GET or SET item per clock while cmd_stall is low and
// returns one result item for each, in order: the item is held in the input
// register, the entry store compares its key and updates the age ranks across
// all entries in parallel, and the result is registered. The result register
// lets a new item enter while a finished result waits. Capacity is written
// over APB at byte address 0 (reset 16; zero acts as one, values above the
// built entry count saturate) and should only change while the cache is idle.
// Valid bits, ages and the occupancy count clear at reset; no clearing pass.
module lru_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  req_t                  cmd,

    output logic                  res_valid,
    input  logic                  res_stall,
    output rsp_t                  res,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic             cap_sel;
    logic [CAP_W-1:0] cap_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    req_t             in_item_reg;
    logic             res_valid_reg;
    rsp_t             res_reg;
    rsp_t             store_rsp;
    logic             advance;
    logic             accept;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[2] == REG_CAPACITY);
    assign prdata  = cap_sel ? APB_DATA_W'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && cap_sel)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign advance   = !res_valid_reg || !res_stall;
    assign cmd_stall = in_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= cmd;
        end
        if (advance && in_valid_reg)
        begin
            res_reg <= store_rsp;
        end
    end

    lkvc_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd_en   (advance && in_valid_reg),
        .req      (in_item_reg),
        .capacity (cap_reg),
        .rsp      (store_rsp)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### rtl/core/lkvc_store.sv
// ============================================================================
// LRU key-value cache entry store
// Fully associative entries with age ranks; lookup, insert, evict and
// recency update for one item per cycle when upd_en is high.
// ============================================================================
module lkvc_store
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             upd_en,
    input  req_t             req,
    input  logic [CAP_W-1:0] capacity,
    output rsp_t             rsp
);

    localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [AGE_W-1:0]   age_reg  [ENTRIES];
    logic [AGE_W-1:0]   age_next [ENTRIES];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [KEY_W-1:0]   key_reg  [ENTRIES];
    logic [DATA_W-1:0]  data_reg [ENTRIES];

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] oldest_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] free_first;
    logic [ENTRIES-1:0] touch_vec;
    logic [ENTRIES-1:0] key_we;
    logic [ENTRIES-1:0] data_we;
    logic               hit_any;
    logic [DATA_W-1:0]  hit_data;
    logic [AGE_W-1:0]   hit_age;
    logic [AGE_W-1:0]   oldest_age;
    logic [AGE_W-1:0]   touch_old;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic               room;
    logic               is_set;
    logic               do_insert;
    logic               do_evict;
    logic               do_touch;

    always_comb
    begin
        is_set     = (req.operation == OP_SET);
        oldest_age = AGE_W'(count_reg - CNT_W'(1));
        hit_data   = '0;
        hit_age    = '0;
        for (int j = 0; j < ENTRIES; j++)
        begin
            match_vec[j]  = valid_reg[j] && (key_reg[j] == req.key);
            oldest_vec[j] = valid_reg[j] && (age_reg[j] == oldest_age);
            hit_data      = hit_data | ({DATA_W{match_vec[j]}} & data_reg[j]);
            hit_age       = hit_age | ({AGE_W{match_vec[j]}} & age_reg[j]);
        end
        hit_any    = |match_vec;
        free_vec   = ~valid_reg;
        free_first = free_vec & (~free_vec + ENTRIES'(1));

        cap_ext = CMP_W'(capacity);
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        room = CMP_W'(count_reg) < eff_cap;

        do_insert = is_set && !hit_any && room;
        do_evict  = is_set && !hit_any && !room;
        do_touch  = hit_any || do_evict;
        touch_vec = hit_any ? match_vec : oldest_vec;
        touch_old = hit_any ? hit_age : oldest_age;

        valid_next = valid_reg;
        count_next = count_reg;
        for (int j = 0; j < ENTRIES; j++)
        begin
            age_next[j] = age_reg[j];
            key_we[j]   = 1'b0;
            data_we[j]  = 1'b0;
            if (do_insert)
            begin
                if (free_first[j])
                begin
                    valid_next[j] = 1'b1;
                    age_next[j]   = '0;
                    key_we[j]     = 1'b1;
                    data_we[j]    = 1'b1;
                end
                else if (valid_reg[j])
                begin
                    age_next[j] = age_reg[j] + AGE_W'(1);
                end
            end
            else if (do_touch)
            begin
                if (touch_vec[j])
                begin
                    age_next[j] = '0;
                    key_we[j]   = do_evict;
                    data_we[j]  = is_set;
                end
                else if (valid_reg[j] && (age_reg[j] < touch_old))
                begin
                    age_next[j] = age_reg[j] + AGE_W'(1);
                end
            end
        end
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        rsp.hit        = hit_any;
        rsp.read_value = (!is_set && hit_any) ? hit_data : '0;
        rsp.evicted    = do_evict;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int j = 0; j < ENTRIES; j++)
            begin
                age_reg[j] <= '0;
            end
        end
        else if (upd_en)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int j = 0; j < ENTRIES; j++)
            begin
                age_reg[j] <= age_next[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ENTRIES; j++)
        begin
            if (upd_en && key_we[j])
            begin
                key_reg[j] <= req.key;
            end
            if (upd_en && data_we[j])
            begin
                data_reg[j] <= req.value;
            end
        end
    end

endmodule
